### rtl/core/tlbw_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the paging TLB / page walker.
// No dependencies; used by every module under rtl/core.

package tlbw_pkg;

  // TLB geometry
  localparam int TLB_ENTRIES = 1024;
  localparam int IDX_W       = $clog2(TLB_ENTRIES);
  localparam bit IDX_POW2    = ((TLB_ENTRIES & (TLB_ENTRIES - 1)) == 0);
  // floor(2^32 / entries), for the index reduction when entries is not a power of two
  localparam logic [31:0] IDX_RECIP = 32'((64'd1 << 32) / TLB_ENTRIES);

  // Input commands
  localparam logic [1:0] CMD_TRANSLATE = 2'd0;
  localparam logic [1:0] CMD_READ_RET  = 2'd1;
  localparam logic [1:0] CMD_FLUSH     = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_DONE  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;
  localparam logic [1:0] KIND_FAULT = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] linear_addr;
    logic [2:0]  access_len;
    logic        is_user;
    logic        is_write;
    logic [31:0] read_data;
  } tlbw_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] address;
    logic [31:0] write_data;
    logic [2:0]  fault_code;
    logic        last;
  } tlbw_out_t;

  // One TLB entry; rights bit1 = user seen, bit0 = write seen
  typedef struct packed {
    logic        valid;
    logic [19:0] tag;
    logic [19:0] frame;
    logic [1:0]  rights;
  } tlbw_entry_t;

  // Write port of the TLB memory
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    tlbw_entry_t      entry;
  } tlbw_wr_t;

endpackage

### rtl/core/tlbw_tlb.sv
`timescale 1ns / 1ps
// TLB entry store: one synchronous memory, one write port, one registered read port.
// Depends on tlbw_pkg.

module tlbw_tlb (
  input  logic                               clk,
  input  tlbw_pkg::tlbw_wr_t                 wr,
  input  logic [tlbw_pkg::IDX_W-1:0]         rd_idx,
  output tlbw_pkg::tlbw_entry_t              rd_entry
);

  tlbw_pkg::tlbw_entry_t mem [tlbw_pkg::TLB_ENTRIES];

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx] <= wr.entry;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rd_entry <= mem[rd_idx];
  end

endmodule

### rtl/core/tlbw_walk.sv
`timescale 1ns / 1ps
// Lookup, page walk and result sequencing around the TLB memory.
// Depends on tlbw_pkg; drives the ports of tlbw_tlb.

module tlbw_walk (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  tlbw_pkg::tlbw_in_t            item,
  input  logic [19:0]                   dir_base_frame,
  output logic                          busy,
  output tlbw_pkg::tlbw_out_t           result,
  output logic                          result_valid,
  output logic [tlbw_pkg::IDX_W-1:0]    tlb_rd_idx,
  input  tlbw_pkg::tlbw_entry_t         tlb_rd_entry,
  output tlbw_pkg::tlbw_wr_t            tlb_wr
);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_RED   = 3'd2;
  localparam logic [2:0] S_LOOK  = 3'd3;
  localparam logic [2:0] S_WBPTE = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;
  localparam logic [2:0] S_SWEEP = 3'd6;

  // walk phases
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_DIR  = 2'd1;
  localparam logic [1:0] PH_TBL  = 2'd2;

  localparam logic [tlbw_pkg::IDX_W-1:0] SWEEP_LAST =
    tlbw_pkg::IDX_W'(tlbw_pkg::TLB_ENTRIES - 1);
  localparam logic [19:0] ENTRIES_20 = 20'(tlbw_pkg::TLB_ENTRIES);

  logic [2:0]                   state;
  logic [1:0]                   walk_phase;
  logic [tlbw_pkg::IDX_W-1:0]   sweep_cnt;
  logic [31:0]                  pending_linear;
  logic                         pend_user;
  logic                         pend_write;
  logic [tlbw_pkg::IDX_W-1:0]   pending_index;
  logic [1:0]                   pending_rights;
  logic [31:0]                  dir_entry_value;
  logic [31:0]                  dir_entry_addr;
  logic [31:0]                  pte_value;
  logic [19:0]                  vpn;
  logic [19:0]                  qest;

  logic                         accept;
  logic [31:0]                  in_sum;
  logic [19:0]                  in_vpn;
  logic [tlbw_pkg::IDX_W-1:0]   in_idx;
  logic [51:0]                  mul_prod;
  logic [19:0]                  red_prod;
  logic [19:0]                  red_rem;
  logic [19:0]                  red_fix;
  logic [tlbw_pkg::IDX_W-1:0]   red_idx;
  logic                         hit;
  logic                         rights_ok;
  logic [31:0]                  rd;
  logic                         pte_needs_wb;
  logic                         user_fault;
  logic                         fill_go;
  logic [2:0]                   walk_code;
  logic [31:0]                  pte_addr;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // index of the page holding the last byte of the access
  assign in_sum = item.linear_addr + 32'(item.access_len) - 32'd1;
  assign in_vpn = in_sum[31:12];
  assign in_idx = tlbw_pkg::IDX_POW2 ? in_vpn[tlbw_pkg::IDX_W-1:0] : '0;

  // modulo by a non power of two: reciprocal estimate, then one correction
  assign mul_prod = 52'(vpn) * 52'(tlbw_pkg::IDX_RECIP);
  assign red_prod = 20'(qest * ENTRIES_20);
  assign red_rem  = vpn - red_prod;
  assign red_fix  = (red_rem >= ENTRIES_20) ? red_rem - ENTRIES_20 : red_rem;
  assign red_idx  = red_fix[tlbw_pkg::IDX_W-1:0];

  assign tlb_rd_idx = (state == S_RED) ? red_idx : in_idx;

  // lookup decision
  assign hit       = tlb_rd_entry.valid && (tlb_rd_entry.tag == pending_linear[31:12]);
  assign rights_ok = (!pend_user || tlb_rd_entry.rights[1]) &&
                     (!pend_write || tlb_rd_entry.rights[0]);

  // table entry checks
  assign rd           = item.read_data;
  assign pte_needs_wb = !rd[5] || (pend_write && !rd[6]);
  assign user_fault   = pend_user && (!dir_entry_value[2] || !rd[2] ||
                        (pend_write && (!dir_entry_value[1] || !rd[1])));
  assign fill_go      = accept && (item.cmd == tlbw_pkg::CMD_READ_RET) &&
                        (walk_phase == PH_TBL) && rd[0] && !user_fault;
  assign walk_code    = {pend_user, pend_write, 1'b0};
  assign pte_addr     = {dir_entry_value[31:12], pending_linear[21:12], 2'b00};

  // TLB write port: clearing sweep, rights drop on a miss, or fill at the end of a walk
  always_comb begin
    tlb_wr.en           = 1'b0;
    tlb_wr.idx          = pending_index;
    tlb_wr.entry.valid  = 1'b1;
    tlb_wr.entry.tag    = pending_linear[31:12];
    tlb_wr.entry.frame  = rd[31:12];
    tlb_wr.entry.rights = pending_rights | {pend_user, pend_write};
    if (state == S_SWEEP) begin
      tlb_wr.en    = 1'b1;
      tlb_wr.idx   = sweep_cnt;
      tlb_wr.entry = '0;
    end else if (fill_go) begin
      tlb_wr.en = 1'b1;
    end else if ((state == S_LOOK) && !hit) begin
      // miss: entry keeps tag and frame, loses its rights before the walk
      tlb_wr.en           = 1'b1;
      tlb_wr.entry        = tlb_rd_entry;
      tlb_wr.entry.rights = 2'b00;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_SWEEP;
      walk_phase   <= PH_IDLE;
      sweep_cnt    <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            case (item.cmd)
              tlbw_pkg::CMD_FLUSH: begin
                state <= S_SWEEP;
              end
              tlbw_pkg::CMD_TRANSLATE: begin
                if (walk_phase == PH_IDLE) begin
                  pending_linear <= item.linear_addr;
                  pend_user      <= item.is_user;
                  pend_write     <= item.is_write;
                  vpn            <= in_vpn;
                  pending_index  <= in_idx;
                  state          <= tlbw_pkg::IDX_POW2 ? S_LOOK : S_MUL;
                end
              end
              tlbw_pkg::CMD_READ_RET: begin
                if (walk_phase == PH_DIR) begin
                  result_valid <= 1'b1;
                  if (!rd[0]) begin
                    result     <= '{kind: tlbw_pkg::KIND_FAULT, address: pending_linear,
                                    write_data: '0, fault_code: walk_code, last: 1'b1};
                    walk_phase <= PH_IDLE;
                  end else begin
                    dir_entry_value <= rd;
                    result <= '{kind: tlbw_pkg::KIND_READ,
                                address: {rd[31:12], pending_linear[21:12], 2'b00},
                                write_data: '0, fault_code: '0, last: 1'b1};
                    walk_phase <= PH_TBL;
                  end
                end else if (walk_phase == PH_TBL) begin
                  result_valid <= 1'b1;
                  walk_phase   <= PH_IDLE;
                  pte_value    <= rd;
                  if (!rd[0] || user_fault) begin
                    result <= '{kind: tlbw_pkg::KIND_FAULT, address: pending_linear,
                                write_data: '0, fault_code: {walk_code[2:1], rd[0]},
                                last: 1'b1};
                  end else if (!dir_entry_value[5]) begin
                    // directory entry accessed bit first
                    result <= '{kind: tlbw_pkg::KIND_WRITE, address: dir_entry_addr,
                                write_data: dir_entry_value | 32'h20, fault_code: '0,
                                last: 1'b0};
                    state  <= pte_needs_wb ? S_WBPTE : S_DONE;
                  end else if (pte_needs_wb) begin
                    result <= '{kind: tlbw_pkg::KIND_WRITE, address: pte_addr,
                                write_data: rd | 32'h20 | {25'b0, pend_write, 6'b0},
                                fault_code: '0, last: 1'b0};
                    state  <= S_DONE;
                  end else begin
                    result <= '{kind: tlbw_pkg::KIND_DONE,
                                address: {rd[31:12], pending_linear[11:0]},
                                write_data: '0, fault_code: '0, last: 1'b1};
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_MUL: begin
          qest  <= mul_prod[51:32];
          state <= S_RED;
        end
        S_RED: begin
          pending_index <= red_idx;
          state         <= S_LOOK;
        end
        S_LOOK: begin
          result_valid <= 1'b1;
          state        <= S_IDLE;
          if (hit && rights_ok) begin
            result <= '{kind: tlbw_pkg::KIND_DONE,
                        address: {tlb_rd_entry.frame, pending_linear[11:0]},
                        write_data: '0, fault_code: '0, last: 1'b1};
          end else begin
            pending_rights <= hit ? tlb_rd_entry.rights : 2'b00;
            dir_entry_addr <= {dir_base_frame, pending_linear[31:22], 2'b00};
            walk_phase     <= PH_DIR;
            result <= '{kind: tlbw_pkg::KIND_READ,
                        address: {dir_base_frame, pending_linear[31:22], 2'b00},
                        write_data: '0, fault_code: '0, last: 1'b1};
          end
        end
        S_WBPTE: begin
          result_valid <= 1'b1;
          result <= '{kind: tlbw_pkg::KIND_WRITE, address: pte_addr,
                      write_data: pte_value | 32'h20 | {25'b0, pend_write, 6'b0},
                      fault_code: '0, last: 1'b0};
          state  <= S_DONE;
        end
        S_DONE: begin
          result_valid <= 1'b1;
          result <= '{kind: tlbw_pkg::KIND_DONE,
                      address: {pte_value[31:12], pending_linear[11:0]},
                      write_data: '0, fault_code: '0, last: 1'b1};
          state  <= S_IDLE;
        end
        S_SWEEP: begin
          if (sweep_cnt == SWEEP_LAST) begin
            sweep_cnt <= '0;
            state     <= S_IDLE;
          end else begin
            sweep_cnt <= sweep_cnt + 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/core/paging_mmu_tlb_walker_unit.sv
`timescale 1ns / 1ps
// Top level of the paging TLB / two-level page walker.
// Depends on tlbw_pkg, tlbw_tlb and tlbw_walk.
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------
//   command  | start in, busy out     | item   (tlbw_in_t)
//   result   | result_valid out       | result (tlbw_out_t)
//   config   | cfg_valid / cfg_ready  | cfg_data (directory base frame)
//
// A translate that hits is answered from the registered TLB memory read; when the entry
// count is not a power of two, the index reduction (S_MUL, S_RED) comes first. The last
// table return gives up to 3 results on consecutive cycles. Each result beat shows
// for one cycle. After reset and after each flush, busy stays high while the memory
// is swept clear, one entry per cycle.

module paging_mmu_tlb_walker_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  tlbw_pkg::tlbw_in_t   item,
  output logic                 result_valid,
  output tlbw_pkg::tlbw_out_t  result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [19:0]          cfg_data
);

  logic [19:0]                  dir_base_frame;
  logic [tlbw_pkg::IDX_W-1:0]   tlb_rd_idx;
  tlbw_pkg::tlbw_entry_t        tlb_rd_entry;
  tlbw_pkg::tlbw_wr_t           tlb_wr;

  // configuration register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dir_base_frame <= '0;
    end else if (cfg_valid && cfg_ready) begin
      dir_base_frame <= cfg_data;
    end
  end

  tlbw_tlb u_tlb (
    .clk      (clk),
    .wr       (tlb_wr),
    .rd_idx   (tlb_rd_idx),
    .rd_entry (tlb_rd_entry)
  );

  tlbw_walk u_walk (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .item           (item),
    .dir_base_frame (dir_base_frame),
    .busy           (busy),
    .result         (result),
    .result_valid   (result_valid),
    .tlb_rd_idx     (tlb_rd_idx),
    .tlb_rd_entry   (tlb_rd_entry),
    .tlb_wr         (tlb_wr)
  );

endmodule
